// ----- rtl/core/tmcw_pkg.sv -----
// Shared constants and controller/datapath interface types for the text console writer.
package tmcw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;

  localparam int ADDR_W = $clog2(CELLS);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);

  localparam int CODE_W     = 8;
  localparam int IDX_W      = 11;
  localparam int CELL_W     = 16;
  localparam int COLOR_W    = 4;
  localparam int OUT_COL_W  = 7;
  localparam int OUT_ROW_W  = 5;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CODE_W-1:0] NEWLINE_CODE = 8'h0A;
  localparam logic [CODE_W-1:0] SPACE_CODE   = 8'h20;
  localparam logic [CELL_W-1:0] RESET_CELL   = 16'h0720;

  localparam logic [COLOR_W-1:0] FG_RESET = 4'd7;
  localparam logic [COLOR_W-1:0] BG_RESET = 4'd0;

  localparam logic [CFG_IDX_W-1:0] REG_FG_COLOR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BG_COLOR = 1'd1;

  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef struct packed {
    logic clear_wr;
    logic accept;
    logic copy_rd;
    logic fill_wr;
    logic load_read;
    logic load_scroll;
    logic cnt_inc;
    logic cnt_clr;
  } tmcw_cmd_t;

  typedef struct packed {
    logic is_read;
    logic put_scroll;
    logic out_free;
    logic cnt_at_end;
    logic cnt_at_copy_end;
  } tmcw_status_t;

endpackage

// ----- rtl/core/text_mode_console_writer.sv -----
// Top level of the text console writer: stream ports, controller and datapath.
//
// Character console over an 80x25 store of 16-bit cells (attribute high byte,
// character low byte), held in one single-port-write, single-port-read memory.
// After reset the block runs a clearing pass that writes 0x0720 into every
// cell, one cell per cycle, during which in_tready stays low (color writes
// on the cfg_ port are taken at all times, cfg_ready is tied high). Puts that
// do not scroll stream at one beat per clock as long as the result side keeps
// taking beats. A read addresses the memory when it is accepted and forms its
// result from the registered data in the read state. A put that moves past the
// last row scrolls the screen through the same memory port pair: a row-up
// copy, a drain state to land the last copied cell, then an attributed-space
// fill of the last row; its result beat carries scrolled = 1. Every accepted
// beat yields exactly one result beat with the cursor after the item;
// cell_data is zero for puts and for reads past the last cell.
module text_mode_console_writer
  import tmcw_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,   // 0 fg_color, 1 bg_color
  input  logic [COLOR_W-1:0]   cfg_data,
  // input stream
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [23:0]          in_tdata,    // [7:0] char_code, [18:8] cell_index, rest zero
  input  logic                 in_tuser,    // [0] cmd: 0 put, 1 read
  // result stream
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [31:0]          out_tdata    // [6:0] cursor_col, [11:7] cursor_row,
                                            // [27:12] cell_data, [28] scrolled, rest zero
);

  tmcw_cmd_t            cmd;
  tmcw_status_t         st;
  logic [OUT_COL_W-1:0] cursor_col;
  logic [OUT_ROW_W-1:0] cursor_row;
  logic [CELL_W-1:0]    cell_data;
  logic                 scrolled;

  // Color registers never stall a write.
  assign cfg_ready = 1'b1;

  tmcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  tmcw_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_cmd         (in_tuser),
    .in_char_code   (in_tdata[7:0]),
    .in_cell_index  (in_tdata[18:8]),
    .out_tready     (out_tready),
    .out_tvalid     (out_tvalid),
    .out_cursor_col (cursor_col),
    .out_cursor_row (cursor_row),
    .out_cell_data  (cell_data),
    .out_scrolled   (scrolled),
    .cmd            (cmd),
    .st             (st)
  );

  // Pack the result beat, lowest field first.
  assign out_tdata = {3'b000, scrolled, cell_data, cursor_row, cursor_col};

endmodule

// ----- rtl/core/tmcw_ctrl.sv -----
// Sequencer for the console writer: clearing pass, put/read issue, scroll copy and fill.
module tmcw_ctrl
  import tmcw_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  tmcw_status_t st,
  output tmcw_cmd_t    cmd
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_COPY  = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;
  localparam logic [2:0] ST_FILL  = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       acc;

  assign in_tready = (state_r == ST_IDLE) && st.out_free;
  assign acc       = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        cmd.cnt_inc  = 1'b1;
        if (st.cnt_at_end) begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cmd.accept = acc;
        if (acc) begin
          priority if (st.is_read) begin
            state_nxt = ST_READ;
          end else if (st.put_scroll) begin
            state_nxt = ST_COPY;
          end
        end
      end
      ST_READ: begin
        cmd.load_read = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_COPY: begin
        cmd.copy_rd = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (st.cnt_at_copy_end) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_FILL;
      end
      ST_FILL: begin
        cmd.fill_wr = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (st.cnt_at_end) begin
          cmd.cnt_clr     = 1'b1;
          cmd.load_scroll = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_copy_runs_to_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COPY && !st.cnt_at_copy_end) |=> (state_r == ST_COPY))
    else $error("scroll copy left before the last source row");

  a_scroll_put_copies: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && !st.is_read && st.put_scroll) |=> (state_r == ST_COPY))
    else $error("scrolling put did not start the copy");

endmodule

// ----- rtl/core/tmcw_datapath.sv -----
// Screen store, cursor, color registers, sweep counter and result register.
module tmcw_datapath
  import tmcw_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COLOR_W-1:0]   cfg_data,
  input  logic                 in_cmd,
  input  logic [CODE_W-1:0]    in_char_code,
  input  logic [IDX_W-1:0]     in_cell_index,
  input  logic                 out_tready,
  output logic                 out_tvalid,
  output logic [OUT_COL_W-1:0] out_cursor_col,
  output logic [OUT_ROW_W-1:0] out_cursor_row,
  output logic [CELL_W-1:0]    out_cell_data,
  output logic                 out_scrolled,
  input  tmcw_cmd_t            cmd,
  output tmcw_status_t         st
);

  logic [CELL_W-1:0]  mem [CELLS];
  logic [CELL_W-1:0]  rdata_r;

  logic [COLOR_W-1:0] fg_r;
  logic [COLOR_W-1:0] bg_r;
  logic [COL_W-1:0]   col_r;
  logic [COL_W-1:0]   col_nxt;
  logic [ROW_W-1:0]   row_r;
  logic [ROW_W-1:0]   row_nxt;
  logic [ADDR_W-1:0]  cnt_r;
  logic [ADDR_W-1:0]  cnt_nxt;
  logic               pend_r;
  logic [ADDR_W-1:0]  pend_addr_r;
  logic               oob_r;

  logic               out_valid_r;
  logic [OUT_COL_W-1:0] out_col_r;
  logic [OUT_ROW_W-1:0] out_row_r;
  logic [CELL_W-1:0]  out_data_r;
  logic               out_scr_r;

  logic               is_newline;
  logic [COL_W:0]     col_inc;
  logic [ROW_W:0]     row_inc;
  logic               wraps;
  logic               put_scroll;
  logic               put_acc;
  logic               read_acc;
  logic               load_put;
  logic               load_any;
  logic [IDX_W+ADDR_W-1:0] idx_ext;
  logic               idx_in_range;
  logic [ADDR_W-1:0]  put_addr;
  logic [CELL_W-1:0]  attr_cell;
  logic [CELL_W-1:0]  space_cell;

  logic               we;
  logic [ADDR_W-1:0]  waddr;
  logic [CELL_W-1:0]  wdata;
  logic               re;
  logic [ADDR_W-1:0]  raddr;

  assign is_newline = (in_char_code == NEWLINE_CODE);
  assign col_inc    = {1'b0, col_r} + 1'b1;
  assign row_inc    = {1'b0, row_r} + 1'b1;
  assign wraps      = is_newline || (col_inc == (COL_W+1)'(COLUMNS));
  assign put_scroll = wraps && (row_inc == (ROW_W+1)'(ROWS));

  assign put_acc  = cmd.accept && (in_cmd == CMD_PUT);
  assign read_acc = cmd.accept && (in_cmd == CMD_READ);
  assign load_put = put_acc && !put_scroll;
  assign load_any = load_put || cmd.load_read || cmd.load_scroll;

  assign idx_ext      = (IDX_W+ADDR_W)'(in_cell_index);
  assign idx_in_range = (idx_ext < (IDX_W+ADDR_W)'(CELLS));
  assign put_addr     = ADDR_W'(row_r) * ADDR_W'(COLUMNS) + ADDR_W'(col_r);
  assign attr_cell    = {bg_r, fg_r, in_char_code};
  assign space_cell   = {bg_r, fg_r, SPACE_CODE};

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (put_acc) begin
      if (wraps) begin
        col_nxt = '0;
        row_nxt = put_scroll ? ROW_W'(ROWS - 1) : row_inc[ROW_W-1:0];
      end else begin
        col_nxt = col_inc[COL_W-1:0];
      end
    end
  end

  // Write port: the sources never overlap in time.
  always_comb begin
    we    = 1'b0;
    waddr = cnt_r;
    wdata = RESET_CELL;
    priority if (cmd.clear_wr) begin
      we = 1'b1;
    end else if (pend_r) begin
      we    = 1'b1;
      waddr = pend_addr_r;
      wdata = rdata_r;
    end else if (cmd.fill_wr) begin
      we    = 1'b1;
      wdata = space_cell;
    end else if (put_acc && !is_newline) begin
      we    = 1'b1;
      waddr = put_addr;
      wdata = attr_cell;
    end
  end

  always_comb begin
    re    = 1'b0;
    raddr = idx_ext[ADDR_W-1:0];
    priority if (cmd.copy_rd) begin
      re    = 1'b1;
      raddr = cnt_r + ADDR_W'(COLUMNS);
    end else if (read_acc && idx_in_range) begin
      re = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    priority if (cmd.cnt_clr) begin
      cnt_nxt = '0;
    end else if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r        <= FG_RESET;
      bg_r        <= BG_RESET;
      col_r       <= '0;
      row_r       <= '0;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_FG_COLOR: fg_r <= cfg_data;
          REG_BG_COLOR: bg_r <= cfg_data;
          default: ;
        endcase
      end
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      cnt_r  <= cnt_nxt;
      pend_r <= cmd.copy_rd;
      if (load_any) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_addr_r <= cnt_r;
    if (read_acc) begin
      oob_r <= !idx_in_range;
    end
    if (load_any) begin
      out_col_r  <= OUT_COL_W'(col_nxt);
      out_row_r  <= OUT_ROW_W'(row_nxt);
      out_data_r <= (cmd.load_read && !oob_r) ? rdata_r : '0;
      out_scr_r  <= cmd.load_scroll;
    end
  end

  assign st.is_read         = (in_cmd == CMD_READ);
  assign st.put_scroll      = put_scroll;
  assign st.out_free        = !out_valid_r || out_tready;
  assign st.cnt_at_end      = (cnt_r == ADDR_W'(CELLS - 1));
  assign st.cnt_at_copy_end = (cnt_r == ADDR_W'(CELLS - COLUMNS - 1));

  assign out_tvalid     = out_valid_r;
  assign out_cursor_col = out_col_r;
  assign out_cursor_row = out_row_r;
  assign out_cell_data  = out_data_r;
  assign out_scrolled   = out_scr_r;

  a_cursor_in_screen: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> ({1'b0, col_r} < (COL_W+1)'(COLUMNS)) && ({1'b0, row_r} < (ROW_W+1)'(ROWS)))
    else $error("cursor left the screen");

  a_no_result_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_read || cmd.load_scroll) |-> (!out_valid_r || out_tready))
    else $error("result loaded over an untaken beat");

endmodule
